[rtl/core/psgd_pkg.sv]
// Shared types and constants of the per-flow sequence gap detector.
`default_nettype none
package psgd_pkg;

    localparam int DEF_DEVICES    = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [7:0] BCAST_RESET = 8'hFF;

    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] sender_id;
        logic [7:0] receiver_id;
        logic [7:0] packet_counter;
    } t_in_req;

    typedef struct packed {
        logic signed [8:0] miss_diff;
        logic              miss_flag;
        logic              ignored;
        logic [15:0]       miss_count;
    } t_out_rsp;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // capture request, issue table read
        logic exec;        // evaluate, write back, load result
        logic sweep_wr;    // zero one table entry, advance sweep address
        logic sweep_seen;  // sweep also clears seen bits
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic req_clear;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/core/psgd_ctrl.sv]
// Sequencing state machine of the gap detector.
`default_nettype none
module psgd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  psgd_pkg::t_dp_sts i_sts,
    output psgd_pkg::t_dp_ctl o_ctl
);
    import psgd_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state           = r_state;
        o_ctl             = '0;
        unique case (r_state)
            S_INIT: begin
                o_ctl.sweep_wr   = 1'b1;
                o_ctl.sweep_seen = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.req_clear) begin
                    n_state = S_SWEEP;
                end else if (i_sts.out_free) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SWEEP: begin
                o_ctl.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready raised outside idle");
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && i_sts.sweep_last) |=> (r_state == S_FIN))
        else $error("clear sweep did not finish into result stage");
    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && i_sts.sweep_last) |=> o_in_ready)
        else $error("not ready after init sweep");
`endif

endmodule
`default_nettype wire

[rtl/core/psgd_dpath.sv]
// Pair tables, request registers, evaluation and result register.
`default_nettype none
module psgd_dpath #(
    parameter int DEVICES    = psgd_pkg::DEF_DEVICES,
    parameter int COUNT_BITS = psgd_pkg::DEF_COUNT_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  psgd_pkg::t_in_req  i_in,
    input  wire                i_cfg_valid,
    input  wire  [7:0]         i_cfg_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output psgd_pkg::t_out_rsp o_out,
    input  psgd_pkg::t_dp_ctl  i_ctl,
    output psgd_pkg::t_dp_sts  o_sts
);
    import psgd_pkg::*;

    localparam int         PAIRS     = DEVICES * DEVICES;
    localparam int         PAIR_BITS = $clog2(PAIRS);
    localparam logic [8:0] DEV_W     = 9'(DEVICES);

    // tables
    logic                  seen_mem [PAIRS];
    logic [7:0]            exp_mem  [PAIRS];
    logic [COUNT_BITS-1:0] cnt_mem  [PAIRS];

    logic [7:0]            r_bcast;
    t_in_req               r_req;
    logic                  r_in_range;
    logic [PAIR_BITS-1:0]  r_idx;
    logic [PAIR_BITS-1:0]  r_sweep;
    logic                  r_seen_q;
    logic [7:0]            r_exp_q;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_out_valid;
    t_out_rsp              r_out;

    logic                  in_range;
    logic [16:0]           idx_prod;
    logic [PAIR_BITS-1:0]  idx;
    logic                  ign;
    logic                  miss;
    logic signed [8:0]     diff;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  tbl_we;
    logic [PAIR_BITS-1:0]  wr_addr;
    logic                  sweep_last;
    t_out_rsp              n_out;

    function automatic logic [15:0] shown(input logic [COUNT_BITS-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'h0_0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    // pair index of the incoming request
    assign in_range = ({1'b0, i_in.sender_id} < DEV_W) && ({1'b0, i_in.receiver_id} < DEV_W);
    assign idx_prod = 17'({9'd0, i_in.sender_id} * DEV_W) + {9'd0, i_in.receiver_id};
    assign idx      = in_range ? PAIR_BITS'(idx_prod) : '0;

    assign sweep_last = (r_sweep == PAIR_BITS'(PAIRS - 1));

    always_comb begin
        miss    = r_seen_q && (r_exp_q != r_req.packet_counter);
        diff    = $signed({1'b0, r_req.packet_counter}) - $signed({1'b0, r_exp_q});
        new_cnt = (miss && !(&r_cnt_q)) ? r_cnt_q + COUNT_BITS'(1) : r_cnt_q;
        ign     = 1'b0;
        n_out   = '0;
        unique case (r_req.cmd)
            CMD_CHECK: begin
                ign           = (r_req.sender_id == r_bcast) || !r_in_range;
                n_out.ignored = ign;
                if (!ign) begin
                    n_out.miss_flag  = miss;
                    n_out.miss_diff  = miss ? diff : 9'sd0;
                    n_out.miss_count = shown(new_cnt);
                end
            end
            CMD_READ: begin
                n_out.ignored = !r_in_range;
                if (r_in_range) begin
                    n_out.miss_count = shown(r_cnt_q);
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
        tbl_we  = i_ctl.exec && (r_req.cmd == CMD_CHECK) && !ign;
        wr_addr = i_ctl.sweep_wr ? r_sweep : r_idx;
    end

    // table ports
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_seen_q <= seen_mem[idx];
            r_exp_q  <= exp_mem[idx];
            r_cnt_q  <= cnt_mem[idx];
        end
        if (tbl_we || (i_ctl.sweep_wr && i_ctl.sweep_seen)) begin
            seen_mem[wr_addr] <= tbl_we;
        end
        if (tbl_we || i_ctl.sweep_wr) begin
            cnt_mem[wr_addr] <= tbl_we ? new_cnt : '0;
        end
        if (tbl_we) begin
            exp_mem[wr_addr] <= r_req.packet_counter + 8'd1;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_req      <= i_in;
            r_in_range <= in_range;
            r_idx      <= idx;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast     <= BCAST_RESET;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bcast <= i_cfg_data;
            end
            if (i_ctl.sweep_wr) begin
                r_sweep <= sweep_last ? '0 : r_sweep + PAIR_BITS'(1);
            end
            if (i_ctl.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;
    assign o_sts.sweep_last = sweep_last;
    assign o_sts.req_clear  = (r_req.cmd == CMD_CLEAR);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.exec |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");
    a_exec_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.exec |=> r_out_valid)
        else $error("evaluated request produced no result");
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.exec && i_ctl.sweep_wr))
        else $error("sweep and write-back collide on table port");
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.miss_flag && r_out.ignored))
        else $error("result both missed and ignored");
`endif

endmodule
`default_nettype wire

[rtl/core/per_flow_sequence_gap_detector_unit.sv]
// Top level of the per-flow packet sequence gap detector.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in  (t_in_req)
//  out     | output    | o_out_valid / i_out_ready    | o_out (t_out_rsp)
//  cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_data (broadcast id)
//
// Check and read requests: the accept cycle issues the registered read of the
//   pair tables; evaluation, which writes back only for checks, waits until
//   the result register is free.
// A clear request zeroes the count table one entry per cycle through its single write port.
// After reset the seen and count tables are swept with o_in_ready low; config
//   writes are taken throughout.
// A result waits in the output register; a stalled result holds the next
//   request in evaluation until the register frees up.
`default_nettype none
module per_flow_sequence_gap_detector_unit #(
    parameter int DEVICES    = psgd_pkg::DEF_DEVICES,
    parameter int COUNT_BITS = psgd_pkg::DEF_COUNT_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  psgd_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output psgd_pkg::t_out_rsp o_out,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [7:0]         i_cfg_data
);
    import psgd_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    // broadcast id register never stalls a write
    assign o_cfg_ready = 1'b1;

    psgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    psgd_dpath #(
        .DEVICES    (DEVICES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire
